// ===== hdl/lsi_pkg.sv =====
// Shared types and constants for the line segment intersection block.
package lsi_pkg;

  // coordinate field width on the input word
  localparam int FIELD_BITS = 16;
  // width of a result coordinate
  localparam int OUT_BITS   = 32;
  // quotient bits kept by the divider: one beyond the output range
  localparam int QUO_BITS   = OUT_BITS + 1;
  // number of coordinate lanes (x and y)
  localparam int LANES      = 2;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] a_start_x;
    logic signed [FIELD_BITS-1:0] a_start_y;
    logic signed [FIELD_BITS-1:0] a_end_x;
    logic signed [FIELD_BITS-1:0] a_end_y;
    logic signed [FIELD_BITS-1:0] b_start_x;
    logic signed [FIELD_BITS-1:0] b_start_y;
    logic signed [FIELD_BITS-1:0] b_end_x;
    logic signed [FIELD_BITS-1:0] b_end_y;
    logic                         infinite_lines;
  } lsi_in_t;

  typedef struct packed {
    logic                       found;
    logic signed [OUT_BITS-1:0] cross_x;
    logic signed [OUT_BITS-1:0] cross_y;
    logic                       saturated;
  } lsi_out_t;

  // control that travels with each word down the pipe
  typedef struct packed {
    logic valid;
    logic found;
  } lsi_ctl_t;

endpackage

// ===== hdl/line_segment_intersection.sv =====
// Top level: line or segment intersection point in signed fixed point.
//
// Fully pipelined: a word is taken on every cycle that start is high (busy
// never rises) and its result leaves the output register, marked by
// out_strobe for one cycle. The pipe is five front stages (differences,
// cross products, hit test, scaling products, dividend), one divider entry
// stage, one stage per quotient bit of the 33-bit restoring divider, and the
// output register. Results must be taken when strobed; there is no holding.
// Parallel or degenerate lines, and segments that miss in segment mode,
// give found low with a zero point.
module line_segment_intersection #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lsi_pkg::lsi_in_t   in_word,
  output logic               out_strobe,
  output lsi_pkg::lsi_out_t  out_word
);
  import lsi_pkg::*;

  localparam int DENW = 2 * COORD_BITS + 5;
  localparam int DVW  = 3 * COORD_BITS + 7 + FRAC_BITS;
  localparam int LAT  = 7 + QUO_BITS;

  localparam logic [QUO_BITS-1:0] POS_MAX = QUO_BITS'(33'h0_7FFF_FFFF);
  localparam logic [QUO_BITS-1:0] NEG_MAX = QUO_BITS'(33'h0_8000_0000);

  assign busy = 1'b0;

  lsi_ctl_t         f_ctl, d_ctl;
  logic [DVW-1:0]   f_dvd [LANES];
  logic [LANES-1:0] f_neg, d_neg, d_ovf;
  logic [DENW-1:0]  f_den;
  logic [QUO_BITS-1:0] d_quo [LANES];

  lsi_front #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .DENW      (DENW),
    .DVW       (DVW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start && !busy),
    .in_word (in_word),
    .ctl     (f_ctl),
    .dvd     (f_dvd),
    .neg     (f_neg),
    .den     (f_den)
  );

  lsi_divider #(
    .DENW(DENW),
    .DVW (DVW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (f_ctl),
    .dvd    (f_dvd),
    .neg_in (f_neg),
    .den    (f_den),
    .ctl_out(d_ctl),
    .quo    (d_quo),
    .ovf    (d_ovf),
    .neg_out(d_neg)
  );

  // sign restore and clip to 32 bits
  logic [OUT_BITS-1:0] val [LANES];
  logic [LANES-1:0]    clip;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (d_neg[l]) begin
        clip[l] = d_ovf[l] || (d_quo[l] > NEG_MAX);
        val[l]  = clip[l] ? NEG_MAX[OUT_BITS-1:0] : OUT_BITS'(-d_quo[l]);
      end else begin
        clip[l] = d_ovf[l] || (d_quo[l] > POS_MAX);
        val[l]  = clip[l] ? POS_MAX[OUT_BITS-1:0] : d_quo[l][OUT_BITS-1:0];
      end
    end
  end

  logic     strobe_r;
  lsi_out_t word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= d_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    word_r.found     <= d_ctl.found;
    word_r.cross_x   <= d_ctl.found ? $signed(val[0]) : '0;
    word_r.cross_y   <= d_ctl.found ? $signed(val[1]) : '0;
    word_r.saturated <= d_ctl.found && (clip != '0);
  end

  assign out_strobe = strobe_r;
  assign out_word   = word_r;

  // a strobed word always traces back to an earlier start
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result strobe without matching start");

  // a miss carries a zero point and no clip flag
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_word.found) |->
      (out_word.cross_x == '0 && out_word.cross_y == '0 && !out_word.saturated))
    else $error("miss result with nonzero payload");

  // clipping only reported on a found point
  a_sat_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.saturated) |-> out_word.found)
    else $error("saturated without found");

endmodule

// ===== hdl/lsi_front.sv =====
// Front pipeline: differences, cross products, hit test and dividend forming.
module lsi_front #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8,
  parameter int DENW       = 2 * COORD_BITS + 5,
  parameter int DVW        = 3 * COORD_BITS + 7 + FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  lsi_pkg::lsi_in_t        in_word,
  output lsi_pkg::lsi_ctl_t       ctl,
  output logic [DVW-1:0]          dvd [lsi_pkg::LANES],
  output logic [lsi_pkg::LANES-1:0] neg,
  output logic [DENW-1:0]         den
);
  import lsi_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int EXT  = (CB > FIELD_BITS) ? CB : FIELD_BITS;
  localparam int DW   = CB + 1;
  localparam int PW   = 2 * DW;
  localparam int NUMW = DENW + DW + 1;

  // low COORD_BITS of the zero-extended field, taken as two's complement
  function automatic logic signed [CB-1:0] coord(input logic [FIELD_BITS-1:0] f);
    logic [EXT-1:0] z;
    z = EXT'(f);
    return $signed(z[CB-1:0]);
  endfunction

  logic signed [CB-1:0] ax, ay, aex, aey, bsx, bsy, bex, bey;
  always_comb begin
    ax  = coord(in_word.a_start_x);
    ay  = coord(in_word.a_start_y);
    aex = coord(in_word.a_end_x);
    aey = coord(in_word.a_end_y);
    bsx = coord(in_word.b_start_x);
    bsy = coord(in_word.b_start_y);
    bex = coord(in_word.b_end_x);
    bey = coord(in_word.b_end_y);
  end

  // stage 1: direction and offset vectors
  logic signed [DW-1:0] bx_r, by_r, dx_r, dy_r, cx_r, cy_r;
  logic signed [CB-1:0] ax1_r, ay1_r;
  logic                 inf1_r, v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    bx_r   <= DW'(aex) - DW'(ax);
    by_r   <= DW'(aey) - DW'(ay);
    dx_r   <= DW'(bex) - DW'(bsx);
    dy_r   <= DW'(bey) - DW'(bsy);
    cx_r   <= DW'(bsx) - DW'(ax);
    cy_r   <= DW'(bsy) - DW'(ay);
    ax1_r  <= ax;
    ay1_r  <= ay;
    inf1_r <= in_word.infinite_lines;
  end

  // stage 2: six cross product terms
  logic signed [PW-1:0] p_bxdy_r, p_bydx_r, p_cxdy_r, p_cydx_r, p_cxby_r, p_cybx_r;
  logic signed [DW-1:0] bx2_r, by2_r;
  logic signed [CB-1:0] ax2_r, ay2_r;
  logic                 inf2_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_bxdy_r <= bx_r * dy_r;
    p_bydx_r <= by_r * dx_r;
    p_cxdy_r <= cx_r * dy_r;
    p_cydx_r <= cy_r * dx_r;
    p_cxby_r <= cx_r * by_r;
    p_cybx_r <= cy_r * bx_r;
    bx2_r    <= bx_r;
    by2_r    <= by_r;
    ax2_r    <= ax1_r;
    ay2_r    <= ay1_r;
    inf2_r   <= inf1_r;
  end

  // stage 3: den, t and u numerators, sign made positive, hit test
  logic signed [DENW-1:0] den_s, tn_s, un_s, den_p, tn_p, un_p;
  logic                   hit;
  always_comb begin
    den_s = DENW'(p_bxdy_r) - DENW'(p_bydx_r);
    tn_s  = DENW'(p_cxdy_r) - DENW'(p_cydx_r);
    un_s  = DENW'(p_cxby_r) - DENW'(p_cybx_r);
    if (den_s < 0) begin
      den_p = -den_s;
      tn_p  = -tn_s;
      un_p  = -un_s;
    end else begin
      den_p = den_s;
      tn_p  = tn_s;
      un_p  = un_s;
    end
    hit = (den_s != '0) &&
          (inf2_r || ((tn_p >= 0) && (tn_p <= den_p) && (un_p >= 0) && (un_p <= den_p)));
  end

  logic signed [DENW-1:0] den3_r, tn3_r;
  logic signed [DW-1:0]   bx3_r, by3_r;
  logic signed [CB-1:0]   ax3_r, ay3_r;
  lsi_ctl_t               ctl3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r.valid <= 1'b0;
    end else begin
      ctl3_r.valid <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ctl3_r.found <= hit;
    den3_r       <= den_p;
    tn3_r        <= tn_p;
    bx3_r        <= bx2_r;
    by3_r        <= by2_r;
    ax3_r        <= ax2_r;
    ay3_r        <= ay2_r;
  end

  // stage 4: p*den and tn*dir for each lane
  logic signed [CB+DENW-1:0] pd_x, pd_y, pd_x_r, pd_y_r;
  logic signed [DENW+DW-1:0] td_x, td_y, td_x_r, td_y_r;
  logic signed [DENW-1:0]    den4_r;
  lsi_ctl_t                  ctl4_r;

  assign pd_x = ax3_r * den3_r;
  assign pd_y = ay3_r * den3_r;
  assign td_x = tn3_r * bx3_r;
  assign td_y = tn3_r * by3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r.valid <= 1'b0;
    end else begin
      ctl4_r.valid <= ctl3_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl4_r.found <= ctl3_r.found;
    pd_x_r       <= pd_x;
    pd_y_r       <= pd_y;
    td_x_r       <= td_x;
    td_y_r       <= td_y;
    den4_r       <= den3_r;
  end

  // stage 5: numerator magnitude scaled by the fraction bits
  logic signed [NUMW-1:0] num [LANES];
  logic [NUMW-1:0]        mag [LANES];
  logic [DVW-1:0]         dvd_r [LANES];
  logic [LANES-1:0]       neg_r;
  logic [DENW-1:0]        den_r;
  lsi_ctl_t               ctl_r;

  always_comb begin
    num[0] = NUMW'(pd_x_r) + NUMW'(td_x_r);
    num[1] = NUMW'(pd_y_r) + NUMW'(td_y_r);
    for (int l = 0; l < LANES; l++) begin
      mag[l] = (num[l] < 0) ? $unsigned(-num[l]) : $unsigned(num[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl4_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r.found <= ctl4_r.found;
    den_r       <= $unsigned(den4_r);
    for (int l = 0; l < LANES; l++) begin
      neg_r[l] <= num[l] < 0;
      dvd_r[l] <= DVW'(mag[l]) << FRAC_BITS;
    end
  end

  assign ctl = ctl_r;
  assign dvd = dvd_r;
  assign neg = neg_r;
  assign den = den_r;

endmodule

// ===== hdl/lsi_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, both lanes.
module lsi_divider #(
  parameter int DENW = 37,
  parameter int DVW  = 63
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lsi_pkg::lsi_ctl_t                 ctl_in,
  input  logic [DVW-1:0]                    dvd [lsi_pkg::LANES],
  input  logic [lsi_pkg::LANES-1:0]         neg_in,
  input  logic [DENW-1:0]                   den,
  output lsi_pkg::lsi_ctl_t                 ctl_out,
  output logic [lsi_pkg::QUO_BITS-1:0]      quo [lsi_pkg::LANES],
  output logic [lsi_pkg::LANES-1:0]         ovf,
  output logic [lsi_pkg::LANES-1:0]         neg_out
);
  import lsi_pkg::*;

  localparam int QB = QUO_BITS;
  localparam int XW = DVW + QB;
  localparam int RW = DENW;

  logic [RW-1:0]    rem_r  [QB+1][LANES];
  logic [QB-1:0]    low_r  [QB+1][LANES];
  logic [QB-1:0]    quo_r  [QB+1][LANES];
  logic [LANES-1:0] ovf_r  [QB+1];
  logic [LANES-1:0] neg_r  [QB+1];
  logic [DENW-1:0]  den_r  [QB+1];
  lsi_ctl_t         ctl_r  [QB+1];

  // entry: high part must be below den, else quotient overflows
  logic [XW-1:0] xw  [LANES];
  logic [XW-1:0] top [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xw[l]  = XW'(dvd[l]);
      top[l] = xw[l] >> QB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].valid <= 1'b0;
    end else begin
      ctl_r[0].valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r[0].found <= ctl_in.found;
    den_r[0]       <= den;
    neg_r[0]       <= neg_in;
    for (int l = 0; l < LANES; l++) begin
      ovf_r[0][l] <= top[l] >= XW'(den);
      rem_r[0][l] <= RW'(top[l]);
      low_r[0][l] <= xw[l][QB-1:0];
      quo_r[0][l] <= '0;
    end
  end

  // one shift, compare and subtract per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [RW-1:0] r2 [LANES];
    logic [LANES-1:0] ge;
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        r2[l] = {rem_r[k][l][RW-2:0], low_r[k][l][QB-1]};
        ge[l] = r2[l] >= den_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1].valid <= 1'b0;
      end else begin
        ctl_r[k+1].valid <= ctl_r[k].valid;
      end
    end

    always_ff @(posedge clk) begin
      ctl_r[k+1].found <= ctl_r[k].found;
      den_r[k+1]       <= den_r[k];
      neg_r[k+1]       <= neg_r[k];
      ovf_r[k+1]       <= ovf_r[k];
      for (int l = 0; l < LANES; l++) begin
        rem_r[k+1][l] <= ge[l] ? (r2[l] - den_r[k]) : r2[l];
        low_r[k+1][l] <= low_r[k][l] << 1;
        quo_r[k+1][l] <= {quo_r[k][l][QB-2:0], ge[l]};
      end
    end
  end

  assign ctl_out = ctl_r[QB];
  assign quo     = quo_r[QB];
  assign ovf     = ovf_r[QB];
  assign neg_out = neg_r[QB];

endmodule

// ===== verif/line_segment_intersection_tb.sv =====
// Self-checking testbench for the line segment intersection block.
module line_segment_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsi_pkg::*;

  // one directed row: the word, plus a hand-written result where it is obvious
  typedef struct {
    lsi_in_t  w;
    bit       typed;
    lsi_out_t res;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  lsi_in_t  in_word;
  logic     out_strobe;
  lsi_out_t out_word;

  lsi_out_t pending_points[$];
  dir_row_t dir_rows[$];
  int       error_count = 0;
  bit       idle_on = 1;

  line_segment_intersection i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_strobe(out_strobe), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the pipe hangs
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // append one expected result at the tail of the queue
  task automatic expect_word(input lsi_out_t r);
    pending_points.insert(pending_points.size(), r);
  endtask

  // append one directed row
  task automatic add_row(input lsi_in_t w, input bit typed, input lsi_out_t res);
    dir_row_t row;
    row.w = w;
    row.typed = typed;
    row.res = res;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // (p*den + tn*dir) * 2^8 / den, truncated toward zero and clipped to 32 bits
  function automatic logic [31:0] scale_coord(input longint p, input longint dir,
                                              input longint tn, input longint den,
                                              inout bit clipped);
    logic signed [127:0] pw, dw, tw, nw, num, quo;
    pw = p;
    dw = dir;
    tw = tn;
    nw = den;
    num = (pw * nw + tw * dw) * 256;
    quo = num / nw;
    if (quo > 128'sd2147483647) begin
      clipped = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (quo < -128'sd2147483648) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return quo[31:0];
  endfunction

  function automatic lsi_out_t predict_crossing(input lsi_in_t w);
    longint bx, by, dx, dy, cx, cy, den, tn, un;
    bit clipped;
    lsi_out_t r;
    r = '0;
    clipped = 1'b0;
    bx = longint'(w.a_end_x) - longint'(w.a_start_x);
    by = longint'(w.a_end_y) - longint'(w.a_start_y);
    dx = longint'(w.b_end_x) - longint'(w.b_start_x);
    dy = longint'(w.b_end_y) - longint'(w.b_start_y);
    cx = longint'(w.b_start_x) - longint'(w.a_start_x);
    cy = longint'(w.b_start_y) - longint'(w.a_start_y);
    den = bx * dy - by * dx;
    // parallel, collinear or zero-length: nothing reported
    if (den == 0) return r;
    tn = cx * dy - cy * dx;
    un = cx * by - cy * bx;
    if (den < 0) begin
      den = -den;
      tn = -tn;
      un = -un;
    end
    // segment mode: both parameters inside [0,1], endpoints included
    if (!w.infinite_lines && (tn < 0 || tn > den || un < 0 || un > den)) return r;
    r.found = 1'b1;
    r.cross_x = scale_coord(longint'(w.a_start_x), bx, tn, den, clipped);
    r.cross_y = scale_coord(longint'(w.a_start_y), by, tn, den, clipped);
    r.saturated = clipped;
    return r;
  endfunction

  function automatic lsi_in_t make_word(input int ax, ay, aex, aey, bsx, bsy, bex, bey,
                                        input bit inf);
    lsi_in_t w;
    w.a_start_x = ax[15:0];
    w.a_start_y = ay[15:0];
    w.a_end_x = aex[15:0];
    w.a_end_y = aey[15:0];
    w.b_start_x = bsx[15:0];
    w.b_start_y = bsy[15:0];
    w.b_end_x = bex[15:0];
    w.b_end_y = bey[15:0];
    w.infinite_lines = inf;
    return w;
  endfunction

  function automatic lsi_out_t make_point(input bit f, input int x, input int y, input bit s);
    lsi_out_t r;
    r.found = f;
    r.cross_x = x;
    r.cross_y = y;
    r.saturated = s;
    return r;
  endfunction

  // random coordinate: mostly small, sometimes anywhere in the field
  function automatic int rand_coord(input int mode);
    case (mode)
      0: return $urandom_range(0, 32) - 16;
      1: return $urandom_range(0, 2000) - 1000;
      default: return int'($signed($urandom() & 32'hFFFF)) - 32768;
    endcase
  endfunction

  function automatic lsi_in_t random_word();
    int m, px, py, k, sx, sy, tx, ty;
    lsi_in_t w;
    m = $urandom_range(0, 2);
    w = make_word(rand_coord(m), rand_coord(m), rand_coord(m), rand_coord(m),
                  rand_coord(m), rand_coord(m), rand_coord(m), rand_coord(m),
                  1'($urandom_range(0, 1)));
    k = $urandom_range(0, 9);
    if (k < 4) begin
      // segments crossing through a common point
      px = rand_coord(1);
      py = rand_coord(1);
      sx = px - int'($urandom_range(1, 500));
      sy = py + int'($urandom_range(0, 500)) - 250;
      tx = px + int'($urandom_range(0, 500)) - 250;
      ty = py - int'($urandom_range(1, 500));
      w = make_word(sx, sy, 2 * px - sx, 2 * py - sy,
                    tx, ty, 2 * px - tx, 2 * py - ty, w.infinite_lines);
    end else if (k == 4) begin
      // second line parallel to the first
      w.b_end_x = w.b_start_x + (w.a_end_x - w.a_start_x);
      w.b_end_y = w.b_start_y + (w.a_end_y - w.a_start_y);
    end else if (k == 5) begin
      // endpoints touching
      w.b_start_x = w.a_end_x;
      w.b_start_y = w.a_end_y;
    end
    return w;
  endfunction

  // present one word, wait for it to be taken, then queue its expected result
  task automatic send_word(input lsi_in_t w, input bit typed, input lsi_out_t res);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    // a hand-written value stands in for the predicted one
    expect_word(typed ? res : predict_crossing(w));
  endtask

  // result checker
  always @(posedge clk) begin
    lsi_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected word", 32'(out_word.found), 32'd0);
      end else begin
        want = pending_points.pop_front();
        if (out_word.found !== want.found)
          report_mismatch("found", 32'(out_word.found), 32'(want.found));
        if (out_word.cross_x !== want.cross_x)
          report_mismatch("cross_x", out_word.cross_x, want.cross_x);
        if (out_word.cross_y !== want.cross_y)
          report_mismatch("cross_y", out_word.cross_y, want.cross_y);
        if (out_word.saturated !== want.saturated)
          report_mismatch("saturated", 32'(out_word.saturated), 32'(want.saturated));
      end
    end
  end

  initial begin
    int n;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;

    // directed rows
    add_row(make_word(0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, make_point(0, 0, 0, 0));
    add_row(make_word(0, 0, 2, 0, 1, -1, 1, 1, 1'b0), 1'b1, make_point(1, 256, 0, 0));
    add_row(make_word(0, 0, 2, 0, 1, -1, 1, 1, 1'b1), 1'b1, make_point(1, 256, 0, 0));
    add_row(make_word(0, 0, 4, 4, 1, 0, 5, 4, 1'b1), 1'b1, make_point(0, 0, 0, 0));
    add_row(make_word(0, 0, 4, 4, 8, 8, 12, 12, 1'b1), 1'b1, make_point(0, 0, 0, 0));
    add_row(make_word(0, 0, 2, 0, 5, -1, 5, 1, 1'b0), 1'b1, make_point(0, 0, 0, 0));
    add_row(make_word(0, 0, 2, 0, 5, -1, 5, 1, 1'b1), 1'b1, make_point(1, 1280, 0, 0));
    add_row(make_word(0, 0, 2, 0, 2, 0, 2, 3, 1'b0), 1'b1, make_point(1, 512, 0, 0));
    add_row(make_word(0, 0, 2, 0, 0, 0, 0, 3, 1'b0), 1'b1, make_point(1, 0, 0, 0));
    add_row(make_word(0, 0, 2, 0, 1, 1, 1, 3, 1'b0), 1'b1, make_point(0, 0, 0, 0));
    add_row(make_word(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 1'b0),
            1'b0, '0);
    add_row(make_word(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768, 1'b1),
            1'b0, '0);
    add_row(make_word(0, 0, 32767, 1, 0, 1, 32766, 2, 1'b1), 1'b0, '0);
    add_row(make_word(0, 0, -32768, 1, 0, 1, -32767, 2, 1'b1), 1'b0, '0);
    add_row(make_word(-32768, -32768, -32767, -32768, 32767, 32767, 32767, 32766, 1'b1),
            1'b0, '0);
    add_row(make_word(0, 0, 3, 1, 1, 0, 0, 3, 1'b0), 1'b0, '0);
    add_row(make_word(0, 0, -3, -7, 1, -5, -4, 0, 1'b1), 1'b0, '0);
    add_row(make_word(-1, -1, -1, -1, -1, -1, -1, -1, 1'b1), 1'b1, make_point(0, 0, 0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
    end

    // random words; a stretch in the middle runs back to back
    for (n = 0; n < 400; n++) begin
      idle_on = !(n >= 150 && n < 250);
      if (n == 300) begin
        @(negedge clk);
        start <= 1'b0;
        wait (pending_points.size() == 0);
      end
      send_word(random_word(), 1'b0, '0);
    end
    @(negedge clk);
    start <= 1'b0;

    wait (pending_points.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
